@@ design/lqms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqms_pkg
// Shared types and constants of the link quality mode selector.
// ----------------------------------------------------------------------------
package lqms_pkg;

    localparam int SCORE_W     = 10;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = SCORE_W + WEIGHT_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int FACTOR_N    = 7;
    localparam int REG_COUNT   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;

    localparam logic [SCORE_W-1:0] QUALITY_MAX   = 10'd1000;
    localparam logic [SCORE_W-1:0] SAFE_BELOW    = 10'd500;
    localparam logic [SCORE_W-1:0] INTERVAL_FAST = 10'd900;
    localparam logic [SCORE_W-1:0] INTERVAL_SLOW = 10'd400;

    typedef enum logic [1:0] {
        TREND_STABLE    = 2'd0,
        TREND_DEGRADING = 2'd1,
        TREND_IMPROVING = 2'd2
    } trend_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_W_RSSI     = 3'd0,
        REG_W_SNR      = 3'd1,
        REG_W_DELIVERY = 3'd2,
        REG_W_LOSS     = 3'd3,
        REG_W_SIZE     = 3'd4,
        REG_W_CRC      = 3'd5,
        REG_W_INTERVAL = 3'd6,
        REG_FAST_LIMIT = 3'd7
    } reg_index_t;

    // Factor scores in weight order: element i is scaled by weight register i
    typedef logic [FACTOR_N-1:0][SCORE_W-1:0]  score_vec_t;
    typedef logic [FACTOR_N-1:0][WEIGHT_W-1:0] weight_vec_t;

endpackage

@@ design/link_quality_mode_selector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_quality_mode_selector
// Scores link reports, forms a weighted link quality index, and selects
// FAST or SAFE mode from the index and its three-report trend.
//
//   channel   direction  handshake           payload
//   s_        in         s_tvalid/s_tready   s_tdata[71:0] link report
//   m_        out        m_tvalid/m_tready   m_tdata[15:0] quality result
//   cfg_      in         cfg_valid/cfg_ready cfg_index[2:0], cfg_data[15:0]
//
// One report per cycle sustained while the output is not stalled; the scores
// of a taken report enter the queue, then load the product stage, then sum,
// trend and mode load the output register.
// Reset is synchronous and active low; weights return to their defaults and
// the history and mode clear. cfg_ready is always high.
// A stalled output holds the whole back section; the front keeps accepting
// until the two-entry queue fills.
// ----------------------------------------------------------------------------
module link_quality_mode_selector (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rssi_dbm[8:0], snr_qdb[16:9], delivery_tenths[26:17], loss_tenths[36:27],
    // packet_bytes[44:37], crc_score_tenths[54:45], interval_ms[70:55], zero[71]
    input  logic [lqms_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // quality_tenths[9:0], trend_code[11:10], mode_safe[12], mode_changed[13],
    // zero[15:14]
    output logic [lqms_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lqms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lqms_pkg::WEIGHT_W-1:0]     cfg_data
);
    import lqms_pkg::*;

    logic [REG_COUNT-1:0][WEIGHT_W-1:0] cfg_reg, cfg_next;
    weight_vec_t weights;
    score_vec_t  front_scores;
    score_vec_t  q_data;
    logic        q_full, q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            cfg_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_W_RSSI]     <= 16'd16384;
            cfg_reg[REG_W_SNR]      <= 16'd13107;
            cfg_reg[REG_W_DELIVERY] <= 16'd9830;
            cfg_reg[REG_W_LOSS]     <= 16'd9830;
            cfg_reg[REG_W_SIZE]     <= 16'd3277;
            cfg_reg[REG_W_CRC]      <= 16'd6554;
            cfg_reg[REG_W_INTERVAL] <= 16'd6554;
            cfg_reg[REG_FAST_LIMIT] <= 16'd5000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign weights  = cfg_reg[FACTOR_N-1:0];
    assign s_tready = !q_full;

    lqms_front u_front (
        .report     (s_tdata),
        .fast_limit (cfg_reg[REG_FAST_LIMIT]),
        .scores     (front_scores)
    );

    lqms_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (s_tvalid),
        .wr_data   (front_scores),
        .full      (q_full),
        .rd_en     (q_pop),
        .rd_data   (q_data),
        .not_empty (q_valid)
    );

    lqms_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .weights  (weights),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_mode_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12] ==
            ((m_tdata[9:0] < SAFE_BELOW) || (m_tdata[11:10] == TREND_DEGRADING))))
        else $error("mode does not follow quality and trend");

    a_quality_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:0] <= QUALITY_MAX))
        else $error("quality above saturation limit");

    a_trend_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:10] != 2'd3))
        else $error("illegal trend code");

    a_queue_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && !s_tready) |=> !s_tready)
        else $error("queue drained while output stalled");

endmodule

@@ design/lqms_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqms_front
// Unpacks a link report and turns each factor into a clamped 0..1000 score.
// ----------------------------------------------------------------------------
module lqms_front (
    input  logic [lqms_pkg::IN_TDATA_W-1:0] report,
    input  logic [15:0]                     fast_limit,
    output lqms_pkg::score_vec_t            scores
);
    import lqms_pkg::*;

    logic signed [8:0]  rssi;
    logic signed [7:0]  snr;
    logic [9:0]         delivery;
    logic [9:0]         loss;
    logic [7:0]         bytes;
    logic [9:0]         crc;
    logic [15:0]        interval;

    logic signed [10:0] rssi_off;
    logic signed [15:0] rssi_t;
    logic signed [10:0] snr_off;
    logic signed [15:0] snr_t;

    logic [7:0]         size_x;
    logic [17:0]        size_n;
    logic [26:0]        size_p;
    logic [10:0]        size_e;
    logic [17:0]        size_r;

    assign rssi     = report[8:0];
    assign snr      = report[16:9];
    assign delivery = report[26:17];
    assign loss     = report[36:27];
    assign bytes    = report[44:37];
    assign crc      = report[54:45];
    assign interval = report[70:55];

    assign rssi_off = {{2{rssi[8]}}, rssi} + 11'sd120;
    assign rssi_t   = 16'(rssi_off) * 16'sd25;
    assign snr_off  = {{3{snr[7]}}, snr} + 11'sd80;
    assign snr_t    = 16'(snr_off) * 16'sd25;

    // x/255 from x*257/65536, which lands on the quotient or one below it
    assign size_x = 8'hFF - bytes;
    assign size_n = 18'(size_x) * 18'd1000;
    assign size_p = {1'b0, size_n, 8'b0} + {9'b0, size_n};
    assign size_e = size_p[26:16];
    assign size_r = size_n - 18'(size_e) * 18'd255;

    always_comb begin
        // negative products truncate toward zero and clamp to zero either way
        if (rssi_t[15]) begin
            scores[REG_W_RSSI] = '0;
        end else if (rssi_t[15:1] > 15'(QUALITY_MAX)) begin
            scores[REG_W_RSSI] = QUALITY_MAX;
        end else begin
            scores[REG_W_RSSI] = rssi_t[10:1];
        end

        if (snr_t[15]) begin
            scores[REG_W_SNR] = '0;
        end else if (snr_t[15:2] > 14'(QUALITY_MAX)) begin
            scores[REG_W_SNR] = QUALITY_MAX;
        end else begin
            scores[REG_W_SNR] = snr_t[11:2];
        end

        scores[REG_W_DELIVERY] = (delivery > QUALITY_MAX) ? QUALITY_MAX : delivery;
        scores[REG_W_LOSS]     = (loss > QUALITY_MAX) ? '0 : QUALITY_MAX - loss;

        if (size_r >= 18'd255) begin
            scores[REG_W_SIZE] = 10'(size_e + 11'd1);
        end else begin
            scores[REG_W_SIZE] = size_e[9:0];
        end

        scores[REG_W_CRC]      = (crc > QUALITY_MAX) ? QUALITY_MAX : crc;
        scores[REG_W_INTERVAL] = (interval <= fast_limit) ? INTERVAL_FAST : INTERVAL_SLOW;
    end

endmodule

@@ design/lqms_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqms_fifo
// Two-entry queue of score sets between the front and back sections.
// ----------------------------------------------------------------------------
module lqms_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  lqms_pkg::score_vec_t wr_data,
    output logic                 full,
    input  logic                 rd_en,
    output lqms_pkg::score_vec_t rd_data,
    output logic                 not_empty
);
    import lqms_pkg::*;

    score_vec_t            entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/lqms_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqms_back
// Weights the scores, forms the LQI, tracks the trend and picks the mode.
// ----------------------------------------------------------------------------
module lqms_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  lqms_pkg::score_vec_t                q_data,
    output logic                                q_pop,
    input  lqms_pkg::weight_vec_t               weights,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lqms_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import lqms_pkg::*;

    logic                  advance;
    logic                  prod_valid_reg, prod_valid_next;
    logic [PROD_W-1:0]     prod_reg [FACTOR_N];
    logic [ACC_W-1:0]      acc;
    logic [SCORE_W-1:0]    lqi;
    trend_t                trend;
    logic                  mode;
    logic                  load_out;

    logic [SCORE_W-1:0]    hist0_reg, hist1_reg;
    logic [1:0]            fill_reg, fill_next;
    logic                  mode_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // whole pipeline holds while a result waits at the output
    assign advance         = !out_valid_reg || m_tready;
    assign q_pop           = q_valid && advance;
    assign prod_valid_next = advance ? q_valid : prod_valid_reg;
    assign out_valid_next  = advance ? prod_valid_reg : out_valid_reg;
    assign load_out        = advance && prod_valid_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < FACTOR_N; i++) begin
                prod_reg[i] <= {{WEIGHT_W{1'b0}}, q_data[i]}
                             * {{SCORE_W{1'b0}}, weights[i]};
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < FACTOR_N; i++) begin
            acc = acc + ACC_W'(prod_reg[i]);
        end
        lqi = (acc[ACC_W-1:16] > (ACC_W-16)'(QUALITY_MAX)) ? QUALITY_MAX : acc[25:16];

        // history is full once this LQI makes three
        trend = TREND_STABLE;
        if (fill_reg >= 2'd2) begin
            if (hist1_reg > hist0_reg && hist0_reg > lqi) begin
                trend = TREND_DEGRADING;
            end else if (hist1_reg < hist0_reg && hist0_reg < lqi) begin
                trend = TREND_IMPROVING;
            end
        end
        mode      = (lqi < SAFE_BELOW) || (trend == TREND_DEGRADING);
        fill_next = (fill_reg == 2'd3) ? fill_reg : fill_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hist0_reg      <= '0;
            hist1_reg      <= '0;
            fill_reg       <= '0;
            mode_reg       <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
            if (load_out) begin
                hist0_reg <= lqi;
                hist1_reg <= hist0_reg;
                fill_reg  <= fill_next;
                mode_reg  <= mode;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {2'b00, mode != mode_reg, mode, trend, lqi};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
